// File: rtl/tksm_pkg.sv
// -----------------------------------------------------------------------------
// tksm_pkg: shared types and constants for the top-k sorted list merge
// Widths, command and register codes, controller states and the
// controller/datapath command and status structs.
// -----------------------------------------------------------------------------
package tksm_pkg;

  localparam int MAX_K      = 64;
  localparam int ADDR_W     = $clog2(MAX_K);
  localparam int PTR_W      = $clog2(MAX_K + 1);
  localparam int ID_W       = 64;
  localparam int DIST_W     = 32;
  localparam int QI_W       = 16;
  localparam int CMD_W      = 2;
  localparam int TOP_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ENTRY_W    = ID_W + DIST_W;
  localparam int S_TDATA_W  = ENTRY_W;
  localparam int M_TDATA_W  = ID_W + DIST_W + QI_W;

  localparam logic [ID_W-1:0] EMPTY_ID = '1;

  localparam logic [TOP_W-1:0] TOP_COUNT_RST   = TOP_W'(64);
  localparam logic [QI_W-1:0]  QUERY_COUNT_RST = QI_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_NEW = 2'd0,
    CMD_LOAD_RUN = 2'd1,
    CMD_MERGE    = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOP_COUNT   = 2'd0,
    CFG_ASCENDING   = 2'd1,
    CFG_QUERY_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_MERGE
  } state_e;

  typedef struct packed {
    logic load_new;
    logic load_run;
    logic start;
    logic merge_en;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_sts_t;

endpackage

// File: rtl/tksm_ctrl.sv
// -----------------------------------------------------------------------------
// tksm_ctrl: command decode and merge sequencing
// Decodes input words into load/merge commands and steps the merge
// through prepare and emit phases.
// -----------------------------------------------------------------------------
module tksm_ctrl
  import tksm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] in_cmd_i,
  output logic             in_ready_o,
  input  dp_sts_t          sts_i,
  output dp_cmd_t          cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_cmd_i == CMD_MERGE)) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP:  state_d = ST_MERGE;
      ST_MERGE: begin
        if (sts_i.done) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_new = in_valid_i && (in_cmd_i == CMD_LOAD_NEW);
        cmd_o.load_run = in_valid_i && (in_cmd_i == CMD_LOAD_RUN);
        cmd_o.start    = in_valid_i && (in_cmd_i == CMD_MERGE);
      end
      ST_MERGE: begin
        cmd_o.merge_en = 1'b1;
        cmd_o.finish   = sts_i.done;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/tksm_dp.sv
// -----------------------------------------------------------------------------
// tksm_dp: list stores, merge pointers, compare and output register
// Holds both candidate lists in memories, walks them head to head and
// registers one merged word per cycle towards the output, unless it stalls.
// -----------------------------------------------------------------------------
module tksm_dp
  import tksm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // load data
  input  logic [ID_W-1:0]       in_id_i,
  input  logic [DIST_W-1:0]     in_dist_i,
  // control
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  // output word
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [M_TDATA_W-1:0]  out_data_o,
  output logic                  out_last_o
);

  // configuration registers
  logic [TOP_W-1:0] top_count_q;
  logic             ascending_q;
  logic [QI_W-1:0]  query_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q   <= TOP_COUNT_RST;
      ascending_q   <= 1'b1;
      query_count_q <= QUERY_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOP_COUNT:   top_count_q   <= cfg_data_i[TOP_W-1:0];
        CFG_ASCENDING:   ascending_q   <= cfg_data_i[0];
        CFG_QUERY_COUNT: query_count_q <= cfg_data_i[QI_W-1:0];
        default: ;
      endcase
    end
  end

  // fill counts and query counter
  logic [PTR_W-1:0] new_fill_q, run_fill_q;
  logic [QI_W-1:0]  query_q;
  logic [QI_W:0]    query_inc;
  logic             new_wr, run_wr;

  assign new_wr    = cmd_i.load_new && (new_fill_q < PTR_W'(MAX_K));
  assign run_wr    = cmd_i.load_run && (run_fill_q < PTR_W'(MAX_K));
  assign query_inc = {1'b0, query_q} + (QI_W+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      new_fill_q <= '0;
      run_fill_q <= '0;
      query_q    <= '0;
    end else if (cmd_i.finish) begin
      new_fill_q <= '0;
      run_fill_q <= '0;
      query_q    <= (query_inc >= {1'b0, query_count_q}) ? '0 : query_inc[QI_W-1:0];
    end else begin
      if (new_wr) new_fill_q <= new_fill_q + PTR_W'(1);
      if (run_wr) run_fill_q <= run_fill_q + PTR_W'(1);
    end
  end

  // merge pointers and result count
  logic [PTR_W-1:0] a_q, a_d, b_q, b_d, n_q, limit_q;
  logic             emit, take_new;

  assign sts_o.done = (n_q == limit_q);
  assign emit       = cmd_i.merge_en && !sts_o.done && (!out_valid_o || out_ready_i);
  assign a_d        = cmd_i.start ? '0 : a_q + PTR_W'(emit && take_new);
  assign b_d        = cmd_i.start ? '0 : b_q + PTR_W'(emit && !take_new);

  // merge length: whole running list when no new entries, else clamp
  logic [TOP_W-1:0] top_eff;
  logic [PTR_W:0]   total;
  logic [PTR_W-1:0] limit_d;

  always_comb begin
    top_eff = (top_count_q > TOP_W'(MAX_K)) ? TOP_W'(MAX_K) : top_count_q;
    total   = {1'b0, new_fill_q} + {1'b0, run_fill_q};
    if (new_fill_q == '0) begin
      limit_d = run_fill_q;
    end else if ({1'b0, PTR_W'(top_eff)} > total) begin
      limit_d = total[PTR_W-1:0];
    end else begin
      limit_d = PTR_W'(top_eff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q     <= '0;
      b_q     <= '0;
      n_q     <= '0;
      limit_q <= '0;
    end else begin
      a_q <= a_d;
      b_q <= b_d;
      if (cmd_i.start) begin
        n_q     <= '0;
        limit_q <= limit_d;
      end else if (emit) begin
        n_q <= n_q + PTR_W'(1);
      end
    end
  end

  // list memories: one write and one registered read each
  logic [ENTRY_W-1:0] new_mem [MAX_K];
  logic [ENTRY_W-1:0] run_mem [MAX_K];
  logic [ENTRY_W-1:0] new_rd_q, run_rd_q;

  always_ff @(posedge clk_i) begin
    if (new_wr) new_mem[new_fill_q[ADDR_W-1:0]] <= {in_dist_i, in_id_i};
    new_rd_q <= new_mem[a_d[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (run_wr) run_mem[run_fill_q[ADDR_W-1:0]] <= {in_dist_i, in_id_i};
    run_rd_q <= run_mem[b_d[ADDR_W-1:0]];
  end

  // head compare, ties go to the running entry
  logic [ID_W-1:0]          new_id, run_id;
  logic signed [DIST_W-1:0] new_dist, run_dist;

  assign new_id   = new_rd_q[ID_W-1:0];
  assign run_id   = run_rd_q[ID_W-1:0];
  assign new_dist = new_rd_q[ENTRY_W-1:ID_W];
  assign run_dist = run_rd_q[ENTRY_W-1:ID_W];

  always_comb begin
    if (a_q >= new_fill_q) begin
      take_new = 1'b0;
    end else if (b_q >= run_fill_q) begin
      take_new = 1'b1;
    end else begin
      take_new = (run_id == EMPTY_ID) ||
                 (ascending_q ? (new_dist < run_dist) : (new_dist > run_dist));
    end
  end

  // output register
  logic                 out_valid_q, out_last_q;
  logic [M_TDATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {query_q, (take_new ? new_rd_q : run_rd_q)};
      out_last_q <= (n_q + PTR_W'(1) == limit_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

// File: rtl/topk_sorted_list_merge.sv
// -----------------------------------------------------------------------------
// topk_sorted_list_merge: merge of two sorted id/distance lists, top k kept
// Loads a new candidate list and the running result list, then emits the
// best entries of both, best first, one word per cycle unless m_axis stalls.
// -----------------------------------------------------------------------------
//  channel   | dir | handshake                   | payload
//  ----------+-----+-----------------------------+-------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready | tuser: cmd; tdata: id, distance
//  m_axis    | out | m_axis_tvalid/m_axis_tready | tdata: id, distance, query; tlast
//  cfg       | in  | cfg_we_i (no wait)          | cfg_idx_i, cfg_data_i
//
//  A load word is taken while the merge is idle; a load into a full list is dropped.
//  A merge word holds the input off while it runs: a prepare state primes the
//  registered read of both list memories, results follow one a cycle unless the
//  output stalls, and a closing step clears the lists and advances the query.
//  Output stalls hold the merge in place; the output register lets new load
//  words enter while the final result of a merge still waits.
//  Reset clears fill counts, query counter, state and output valid.
// -----------------------------------------------------------------------------
module topk_sorted_list_merge
  import tksm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [63:0] entry_id, [95:64] entry_distance
  input  logic [CMD_W-1:0]      s_axis_tuser,  // [1:0] cmd
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,  // [63:0] result_id, [95:64] result_distance,
                                               // [111:96] query_index
  output logic                  m_axis_tlast   // last result of the merge
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequence loads and merges
  tksm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // stores, compare and output register
  tksm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_id_i     (s_axis_tdata[ID_W-1:0]),
    .in_dist_i   (s_axis_tdata[ENTRY_W-1:ID_W]),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// File: rtl/tksm_checker.sv
// -----------------------------------------------------------------------------
// tksm_checker: port-level checks for the top-k merge
// Watches the stream ports and flags ordering slips of the merge sequence.
// -----------------------------------------------------------------------------
module tksm_checker
  import tksm_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [CMD_W-1:0]     s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  // a merge word blocks the input on the next cycle
  a_merge_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_MERGE) |=> !s_axis_tready)
    else $error("input accepted during merge");

  // a pending non-final result means the merge is still running
  a_run_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready while merge results pending");

  // results of one merge share the query index
  a_query_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      !m_axis_tvalid || $stable(m_axis_tdata[M_TDATA_W-1:ENTRY_W]))
    else $error("query index changed within a merge");

endmodule

bind topk_sorted_list_merge tksm_checker u_tksm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
